// ----- hw/rtl/svia_pkg.sv -----
// ============================================================================
// svia_pkg: shared types and constants of the SIMD vector integer ALU
// Operation codes, vector and lane geometry.
// ============================================================================
package svia_pkg;

    localparam int VEC_W     = 128;
    localparam int LANE_W    = 32;
    localparam int NUM_LANES = VEC_W / LANE_W;
    localparam int KIND_W    = 3;

    typedef enum logic [KIND_W-1:0] {
        OP_ADDS_W = 3'd0,   // signed saturating word add
        OP_SUB_B  = 3'd1,   // modular byte subtract
        OP_AVG_H  = 3'd2,   // signed rounded halfword average
        OP_EQ_H   = 3'd3,   // halfword equality mask
        OP_SHL_B  = 3'd4    // byte shift left
    } op_kind_t;

    localparam logic [LANE_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [LANE_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [15:0]       HALF_ONES = 16'hffff;
    localparam logic [2:0]        SHIFT_MASK = 3'h7;

endpackage

// ----- hw/rtl/simd_vector_integer_alu.sv -----
// ============================================================================
// simd_vector_integer_alu: 128-bit SIMD integer vector ALU
// Four 32-bit lanes run the selected operation side by side; a merge stage
// registers the joined 128-bit result.
// ============================================================================
//
//  channel | ports                         | payload
//  --------+-------------------------------+----------------------------------
//  input   | s_tvalid s_tready s_tdata     | tdata: a_lo a_hi b_lo b_hi
//          | s_tuser                       | tuser: kind
//  result  | m_tvalid m_tready m_tdata     | tdata: r_lo r_hi
//
//  One item per cycle sustained while results are taken; each result is held
//  in the single output register and appears in the cycle after acceptance.
//  s_tready is high whenever the output register is empty or being taken,
//  so a stall on the result side holds the input until the result is taken;
//  the block stores at most one item.
//  aresetn is synchronous, active low, and clears only the valid flag.
//  Undefined kinds (5..7) return an all-zero vector.
//
module simd_vector_integer_alu (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [255:0]  s_tdata,     // a_lo[63:0], a_hi, b_lo, b_hi[255:192]
    input  logic [2:0]    s_tuser,     // kind[2:0]

    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata      // r_lo[63:0], r_hi[127:64]
);

    logic [svia_pkg::VEC_W-1:0]  vec_a;
    logic [svia_pkg::VEC_W-1:0]  vec_b;
    svia_pkg::op_kind_t          kind;
    logic [svia_pkg::NUM_LANES-1:0][svia_pkg::LANE_W-1:0] lane_r;
    logic                        load;

    // operand a is the low half of tdata, operand b the high half
    assign vec_a = s_tdata[svia_pkg::VEC_W-1:0];
    assign vec_b = s_tdata[2*svia_pkg::VEC_W-1:svia_pkg::VEC_W];
    assign kind  = svia_pkg::op_kind_t'(s_tuser);

    // take a new item when the output register is free or draining
    assign s_tready = !m_tvalid || m_tready;
    assign load     = s_tvalid && s_tready;

    // one lane per 32-bit slice; narrower elements stay inside their slice
    for (genvar g = 0; g < svia_pkg::NUM_LANES; g++) begin : g_lane
        svia_lane u_lane (
            .kind (kind),
            .a    (vec_a[g*svia_pkg::LANE_W +: svia_pkg::LANE_W]),
            .b    (vec_b[g*svia_pkg::LANE_W +: svia_pkg::LANE_W]),
            .r    (lane_r[g])
        );
    end

    // join lanes and hold the result until the sink takes it
    svia_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_r    (lane_r),
        .load      (load),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    // an accepted item always produces a result in the next cycle
    a_accept_to_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted item produced no result");

    // a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    // undefined kinds yield an all-zero vector
    a_bad_kind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[2] && (s_tuser[1:0] != 2'b00))
        |=> (m_tdata == '0))
        else $error("undefined kind gave nonzero result");
`endif

endmodule

// ----- hw/rtl/svia_lane.sv -----
// ============================================================================
// svia_lane: one 32-bit slice of the vector datapath
// Computes the selected operation on one word, two halfwords or four bytes.
// ============================================================================
module svia_lane (
    input  svia_pkg::op_kind_t               kind,
    input  logic [svia_pkg::LANE_W-1:0]      a,
    input  logic [svia_pkg::LANE_W-1:0]      b,
    output logic [svia_pkg::LANE_W-1:0]      r
);

    logic [svia_pkg::LANE_W:0]   word_sum;
    logic [svia_pkg::LANE_W-1:0] word_sat;
    logic [svia_pkg::LANE_W-1:0] byte_sub;
    logic [svia_pkg::LANE_W-1:0] byte_shl;
    logic [svia_pkg::LANE_W-1:0] half_avg;
    logic [svia_pkg::LANE_W-1:0] half_eq;
    logic [16:0]                 avg_sum [2];

    // widen by one bit, clamp on sign disagreement
    assign word_sum = {a[31], a} + {b[31], b};
    assign word_sat = (word_sum[32] != word_sum[31])
                    ? (word_sum[32] ? svia_pkg::WORD_MIN : svia_pkg::WORD_MAX)
                    : word_sum[31:0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            byte_sub[i*8 +: 8] = a[i*8 +: 8] - b[i*8 +: 8];
            byte_shl[i*8 +: 8] = a[i*8 +: 8] << (b[i*8 +: 3] & svia_pkg::SHIFT_MASK);
        end
        for (int j = 0; j < 2; j++) begin
            avg_sum[j] = {a[j*16+15], a[j*16 +: 16]} + {b[j*16+15], b[j*16 +: 16]}
                       + 17'd1;
            half_avg[j*16 +: 16] = avg_sum[j][16:1];
            half_eq[j*16 +: 16]  = (a[j*16 +: 16] == b[j*16 +: 16])
                                 ? svia_pkg::HALF_ONES : 16'h0000;
        end
    end

    always_comb begin
        case (kind)
            svia_pkg::OP_ADDS_W: r = word_sat;
            svia_pkg::OP_SUB_B:  r = byte_sub;
            svia_pkg::OP_AVG_H:  r = half_avg;
            svia_pkg::OP_EQ_H:   r = half_eq;
            svia_pkg::OP_SHL_B:  r = byte_shl;
            default:             r = '0;
        endcase
    end

endmodule

// ----- hw/rtl/svia_merge.sv -----
// ============================================================================
// svia_merge: lane merge and output register
// Joins the lane slices into one result vector and holds it until taken.
// ============================================================================
module svia_merge (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic [svia_pkg::NUM_LANES-1:0][svia_pkg::LANE_W-1:0] lane_r,
    input  logic                                          load,
    input  logic                                          out_ready,
    output logic                                          out_valid,
    output logic [svia_pkg::VEC_W-1:0]                    out_data
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [svia_pkg::VEC_W-1:0]   data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // lane i lands on bits [32i+31:32i]
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= lane_r;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- bench/simd_vector_integer_alu_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// simd_vector_integer_alu_test: self-checking bench for the SIMD vector ALU
// Drives operation kinds and operand vectors through the input stream. Each
// result is compared, half by half, with a prediction that the bench computes
// itself. Both stream sides idle at random, and the bench also runs a long
// stall on the result side and a full drain.
// ============================================================================
module simd_vector_integer_alu_test;

    localparam int CLK_PERIOD  = 10;
    localparam int HOLD_CYCLES = 300;   // long result-side stall
    localparam int STALL_LIMIT = 2000;  // cycles without any handshake
    localparam int RAND_ITEMS  = 500;
    localparam int NUM_OPS     = 5;     // defined kinds, OP_ADDS_W .. OP_SHL_B
    localparam int KIND_NONE_LO = 5;    // first kind with no operation
    localparam int KIND_NONE_HI = 7;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the result vector of each accepted item and checks
    // results in order against it.
    // ------------------------------------------------------------------------
    class alu_scoreboard;
        logic [127:0] expected_vectors[$];
        int errors;
        int checked;
        int kind_count[8];

        function new();
            errors  = 0;
            checked = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        // Lanes never cross the 64-bit halves, so work on the full vector.
        function logic [127:0] vector_result(logic [2:0] kind, logic [127:0] a,
                                             logic [127:0] b);
            logic [127:0]      r;
            logic signed [32:0] word_sum;
            logic signed [16:0] half_sum;
            r = '0;
            case (kind)
                svia_pkg::OP_ADDS_W: begin
                    for (int i = 0; i < 4; i++) begin
                        word_sum = $signed({a[32*i+31], a[32*i +: 32]})
                                 + $signed({b[32*i+31], b[32*i +: 32]});
                        // top two bits disagree: the sum left the word range
                        case (word_sum[32:31])
                            2'b01:   r[32*i +: 32] = svia_pkg::WORD_MAX;
                            2'b10:   r[32*i +: 32] = svia_pkg::WORD_MIN;
                            default: r[32*i +: 32] = word_sum[31:0];
                        endcase
                    end
                end
                svia_pkg::OP_SUB_B: begin
                    for (int i = 0; i < 16; i++)
                        r[8*i +: 8] = a[8*i +: 8] - b[8*i +: 8];
                end
                svia_pkg::OP_AVG_H: begin
                    for (int i = 0; i < 8; i++) begin
                        half_sum = $signed({a[16*i+15], a[16*i +: 16]})
                                 + $signed({b[16*i+15], b[16*i +: 16]}) + 17'sd1;
                        r[16*i +: 16] = half_sum[16:1];   // floor of half
                    end
                end
                svia_pkg::OP_EQ_H: begin
                    for (int i = 0; i < 8; i++)
                        r[16*i +: 16] = (a[16*i +: 16] == b[16*i +: 16])
                                      ? svia_pkg::HALF_ONES : '0;
                end
                svia_pkg::OP_SHL_B: begin
                    for (int i = 0; i < 16; i++)
                        r[8*i +: 8] = a[8*i +: 8] << (b[8*i +: 3] & svia_pkg::SHIFT_MASK);
                end
                default: r = '0;
            endcase
            return r;
        endfunction

        function void note_item(logic [2:0] kind, logic [255:0] data);
            expected_vectors.push_back(vector_result(kind, data[127:0], data[255:128]));
            kind_count[kind]++;
        endfunction

        function void check_result(logic [127:0] got);
            logic [127:0] want;
            if (expected_vectors.size() == 0) begin
                $error("result %h arrived with no item outstanding", got);
                errors++;
                return;
            end
            want = expected_vectors.pop_front();
            checked++;
            if (got[63:0] !== want[63:0]) begin
                $error("r_lo: expected %h, actual %h", want[63:0], got[63:0]);
                errors++;
            end
            if (got[127:64] !== want[127:64]) begin
                $error("r_hi: expected %h, actual %h", want[127:64], got[127:64]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_vectors.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata  = '0;     // a_lo, a_hi, b_lo, b_hi (from bit 0 up)
    logic [2:0]   s_tuser  = '0;     // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;           // r_lo, r_hi (from bit 0 up)

    alu_scoreboard sb;
    bit steady   = 1'b0;   // set: neither side idles
    bit hold_req = 1'b0;   // set: receiver holds off for HOLD_CYCLES
    int stall_cycles = 0;

    simd_vector_integer_alu i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Monitor: note accepted items and check accepted results. Values read
    // here are the ones from before the edge, as the block saw them.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: any handshake restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("simd_vector_integer_alu_test: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, none in steady stretches, and one long
    // hold-off on request, counted here.
    // ------------------------------------------------------------------------
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 25);
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    // Offer one item; return at the edge that accepts it. Valid stays high so
    // back-to-back items need no gap.
    task automatic send_item(input logic [2:0] kind, input logic [127:0] a,
                             input logic [127:0] b);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every outstanding result has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Operand with a bias toward word and halfword extremes.
    function automatic logic [127:0] rand_operand();
        logic [127:0] v;
        for (int w = 0; w < 4; w++) begin
            case ($urandom_range(0, 9))
                0:       v[32*w +: 32] = '0;
                1:       v[32*w +: 32] = svia_pkg::WORD_MAX;
                2:       v[32*w +: 32] = svia_pkg::WORD_MIN;
                3:       v[32*w +: 32] = '1;
                4:       v[32*w +: 32] = 32'h7fff_7fff;
                5:       v[32*w +: 32] = 32'h8000_8000;
                default: v[32*w +: 32] = $urandom;
            endcase
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [127:0] a;
        logic [127:0] b;
        logic [2:0]   kind;
        int           pick;

        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: saturation both ways, wrap-around, rounding of negative
        // averages, equality masks, every shift amount, undefined kinds.
        send_item(svia_pkg::OP_ADDS_W, {4{svia_pkg::WORD_MAX}},
                  {svia_pkg::WORD_MAX, 32'h1, 32'h0, svia_pkg::WORD_MIN});
        send_item(svia_pkg::OP_ADDS_W, {4{svia_pkg::WORD_MIN}},
                  {svia_pkg::WORD_MIN, 32'hffff_ffff, 32'h0, svia_pkg::WORD_MAX});
        send_item(svia_pkg::OP_ADDS_W,
                  {32'hffff_ffff, 32'h1, 32'h4000_0000, 32'hc000_0000},
                  {32'h1, 32'hffff_ffff, 32'h4000_0000, 32'hbfff_ffff});
        send_item(svia_pkg::OP_ADDS_W, '0, '0);
        send_item(svia_pkg::OP_SUB_B, '0, {16{8'h01}});
        send_item(svia_pkg::OP_SUB_B, '1, '0);
        send_item(svia_pkg::OP_SUB_B, '1, '1);
        send_item(svia_pkg::OP_SUB_B, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
                                      128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210);
        send_item(svia_pkg::OP_AVG_H, {8{16'h7fff}}, {8{16'h7fff}});
        send_item(svia_pkg::OP_AVG_H, {8{16'h8000}}, {8{16'h8000}});
        send_item(svia_pkg::OP_AVG_H,
                  {16'h8000, 16'hffff, 16'hfffd, 16'h0001,
                   16'h7fff, 16'hffff, 16'h0000, 16'h0003},
                  {16'h7fff, 16'h0000, 16'h0000, 16'h0000,
                   16'h8000, 16'hffff, 16'h0001, 16'h0002});
        send_item(svia_pkg::OP_EQ_H, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
                                     128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210);
        send_item(svia_pkg::OP_EQ_H, '0, '1);
        send_item(svia_pkg::OP_EQ_H, 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210,
                                     128'h0123_0000_89ab_cdef_fedd_ba98_7654_3211);
        send_item(svia_pkg::OP_SHL_B, '1, {2{64'h0706_0504_0302_0100}});
        send_item(svia_pkg::OP_SHL_B, {16{8'h81}}, {2{64'hf8f9_fafb_fcfd_feff}});
        send_item(svia_pkg::OP_SHL_B, '1, '1);
        for (int k = KIND_NONE_LO; k <= KIND_NONE_HI; k++)
            send_item(3'(k), '1, '1);

        // Pause until the directed results are all in
        drain();

        // Random: steady stretch first, then the long hold-off with the sender
        // pushing, a mid-run drain, and random idling elsewhere.
        for (int i = 0; i < RAND_ITEMS; i++) begin
            steady = (i < 120) || (i >= 200 && i < 240);
            if (i == 200)
                hold_req = 1'b1;
            if (i == 320)
                drain();

            pick = $urandom_range(0, 19);
            kind = (pick < 18) ? 3'(pick % NUM_OPS)
                               : 3'($urandom_range(KIND_NONE_LO, KIND_NONE_HI));
            if ($urandom_range(0, 2) == 0) begin
                a = {$urandom, $urandom, $urandom, $urandom};
                b = {$urandom, $urandom, $urandom, $urandom};
            end else begin
                a = rand_operand();
                b = rand_operand();
            end
            // equality: in half the cases a copy of a, each halfword disturbed with chance 1/4
            if (kind == svia_pkg::OP_EQ_H && $urandom_range(0, 1) == 0) begin
                b = a;
                for (int h = 0; h < 8; h++)
                    if ($urandom_range(0, 3) == 0)
                        b[16*h +: 16] = $urandom;
            end
            send_item(kind, a, b);
        end

        drain();
        repeat (4) @(posedge aclk);

        $display("covered %0d results: adds %0d, sub %0d, avg %0d, eq %0d, shl %0d",
                 sb.checked, sb.kind_count[svia_pkg::OP_ADDS_W],
                 sb.kind_count[svia_pkg::OP_SUB_B], sb.kind_count[svia_pkg::OP_AVG_H],
                 sb.kind_count[svia_pkg::OP_EQ_H], sb.kind_count[svia_pkg::OP_SHL_B]);
        $display("undefined %0d; random idling on both sides, a %0d-cycle result stall"
                 , sb.kind_count[5] + sb.kind_count[6] + sb.kind_count[7], HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("simd_vector_integer_alu_test: clean");
        end else begin
            $display("simd_vector_integer_alu_test: errors");
        end
        $finish;
    end

endmodule
